### design/particle_euler_integrator_top_macros.svh
// Assertion macros used by the checker of the particle integrator.
// No dependencies; take it in with `include before the first use.
`ifndef PARTICLE_EULER_INTEGRATOR_TOP_MACROS_SVH
`define PARTICLE_EULER_INTEGRATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PEI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("particle integrator check failed");

// Next-cycle implication, disabled while reset is low.
`define PEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("particle integrator check failed");

`endif

### design/pei_pkg.sv
// Shared types and constants of the particle Euler integrator.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package pei_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 20;
    localparam int DAMP_W    = 17;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_FORCE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_IMPULSE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET_POS = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET_VEL = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MASS_RECIP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING    = 2'd1;

    localparam logic [DATA_W-1:0] MASS_RECIP_RST = 32'd65536;
    localparam logic [DAMP_W-1:0] DAMPING_RST    = 17'd65529;

    typedef logic signed [DATA_W-1:0] t_word;

    // Multiply/finish operation of the shared per-axis multiplier
    typedef enum logic [2:0] {
        OP_IMPULSE = 3'd0,
        OP_ACCEL   = 3'd1,
        OP_POS     = 3'd2,
        OP_VEL     = 3'd3,
        OP_DAMP    = 3'd4
    } t_op;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic fin_en;
        logic out_load;
        t_op  op;
    } t_dp_cmd;

endpackage

### design/pei_ctrl.sv
// Controller of the particle integrator: input/output handshake and the
// multiply/finish sequence. Depends on pei_pkg.
module pei_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [pei_pkg::CMD_W-1:0]     i_command,
    input  logic                          i_out_stall,
    output logic                          o_in_stall,
    output logic                          o_out_valid,
    output pei_pkg::t_dp_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state       r_state, n_state;
    pei_pkg::t_op r_op, n_op;
    logic         r_out_valid, n_out_valid;
    logic         accept;
    logic         out_free;
    logic         out_load;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_OUT) && out_free;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == pei_pkg::CMD_IMPULSE) begin
                        n_op    = pei_pkg::OP_IMPULSE;
                        n_state = S_MUL;
                    end else if (i_command == pei_pkg::CMD_TICK) begin
                        n_op    = pei_pkg::OP_ACCEL;
                        n_state = S_MUL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MUL: n_state = S_FIN;
            S_FIN: begin
                unique case (r_op)
                    pei_pkg::OP_ACCEL: begin
                        n_op    = pei_pkg::OP_POS;
                        n_state = S_MUL;
                    end
                    pei_pkg::OP_POS: begin
                        n_op    = pei_pkg::OP_VEL;
                        n_state = S_MUL;
                    end
                    pei_pkg::OP_VEL: begin
                        n_op    = pei_pkg::OP_DAMP;
                        n_state = S_MUL;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result while the sink stalls; drop it once taken
    assign n_out_valid = out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= pei_pkg::OP_IMPULSE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.load     = accept;
    assign o_cmd.mul_en   = (r_state == S_MUL);
    assign o_cmd.fin_en   = (r_state == S_FIN);
    assign o_cmd.out_load = out_load;
    assign o_cmd.op       = r_op;

endmodule

### design/pei_datapath.sv
// Datapath of the particle integrator: state, configuration, one multiplier
// per axis with round/saturate, and the result register. Depends on pei_pkg.
module pei_datapath #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pei_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pei_pkg::DATA_W-1:0]        i_cfg_wdata,
    input  pei_pkg::t_dp_cmd                  i_cmd,
    input  logic [pei_pkg::CMD_W-1:0]         i_command,
    input  pei_pkg::t_word                    i_vec [3],
    input  logic [pei_pkg::DT_W-1:0]          i_time_step,
    output pei_pkg::t_word                    o_pos [3],
    output pei_pkg::t_word                    o_vel [3],
    output pei_pkg::t_word                    o_force [3]
);

    localparam int SAT_W  = (WORD_WIDTH < 16) ? 16 : ((WORD_WIDTH > 32) ? 32 : WORD_WIDTH);
    localparam int PROD_W = 2 * pei_pkg::DATA_W + 1;
    localparam int EXT_W  = PROD_W - pei_pkg::FRAC_BITS;
    localparam logic signed [EXT_W-1:0] SAT_HI = (EXT_W'(1) <<< (SAT_W - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (pei_pkg::FRAC_BITS - 1);

    function automatic logic signed [EXT_W-1:0] ext(input pei_pkg::t_word w);
        return {{(EXT_W - pei_pkg::DATA_W){w[pei_pkg::DATA_W-1]}}, w};
    endfunction

    function automatic pei_pkg::t_word sat(input logic signed [EXT_W-1:0] v);
        pei_pkg::t_word r;
        if (v > SAT_HI) begin
            r = SAT_HI[pei_pkg::DATA_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[pei_pkg::DATA_W-1:0];
        end else begin
            r = v[pei_pkg::DATA_W-1:0];
        end
        return r;
    endfunction

    logic [pei_pkg::DATA_W-1:0]      r_inv;
    logic [pei_pkg::DAMP_W-1:0]      r_damp;
    logic [pei_pkg::DT_W-1:0]        r_dt;
    pei_pkg::t_word                  r_pos [3];
    pei_pkg::t_word                  r_speed [3];
    pei_pkg::t_word                  r_force [3];
    pei_pkg::t_word                  r_vec [3];
    pei_pkg::t_word                  r_acc [3];
    logic signed [PROD_W-1:0]        r_prod [3];
    pei_pkg::t_word                  r_out_pos [3];
    pei_pkg::t_word                  r_out_vel [3];
    pei_pkg::t_word                  r_out_force [3];

    pei_pkg::t_word                  vec_sat [3];
    pei_pkg::t_word                  mul_a [3];
    logic [pei_pkg::DATA_W-1:0]      mul_b [3];
    logic signed [PROD_W-1:0]        rnd [3];
    pei_pkg::t_word                  prod_q [3];
    pei_pkg::t_word                  sum_pos [3];
    pei_pkg::t_word                  sum_spd [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vec_sat[k] = sat(ext(i_vec[k]));
            unique case (i_cmd.op)
                pei_pkg::OP_IMPULSE: begin
                    mul_a[k] = r_vec[k];
                    mul_b[k] = r_inv;
                end
                pei_pkg::OP_ACCEL: begin
                    mul_a[k] = r_force[k];
                    mul_b[k] = r_inv;
                end
                pei_pkg::OP_POS: begin
                    mul_a[k] = r_speed[k];
                    mul_b[k] = pei_pkg::DATA_W'(r_dt);
                end
                pei_pkg::OP_VEL: begin
                    mul_a[k] = r_acc[k];
                    mul_b[k] = pei_pkg::DATA_W'(r_dt);
                end
                pei_pkg::OP_DAMP: begin
                    mul_a[k] = r_speed[k];
                    mul_b[k] = pei_pkg::DATA_W'(r_damp);
                end
                default: begin
                    mul_a[k] = r_vec[k];
                    mul_b[k] = r_inv;
                end
            endcase
            // Round half up, floor shift, then clamp to the state word
            rnd[k]     = r_prod[k] + ROUND_HALF;
            prod_q[k]  = sat(rnd[k][PROD_W-1:pei_pkg::FRAC_BITS]);
            sum_pos[k] = sat(ext(r_pos[k]) + ext(prod_q[k]));
            sum_spd[k] = sat(ext(r_speed[k]) + ext(prod_q[k]));
        end
    end

    // Control-visible state: configuration and the particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= pei_pkg::MASS_RECIP_RST;
            r_damp <= pei_pkg::DAMPING_RST;
            for (int k = 0; k < 3; k++) begin
                r_pos[k]   <= '0;
                r_speed[k] <= '0;
                r_force[k] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    pei_pkg::CFG_MASS_RECIP: r_inv  <= i_cfg_wdata;
                    pei_pkg::CFG_DAMPING:    r_damp <= i_cfg_wdata[pei_pkg::DAMP_W-1:0];
                    default: ;
                endcase
            end
            for (int k = 0; k < 3; k++) begin
                if (i_cmd.load) begin
                    unique case (i_command)
                        pei_pkg::CMD_FORCE:
                            r_force[k] <= sat(ext(r_force[k]) + ext(vec_sat[k]));
                        pei_pkg::CMD_SET_POS: r_pos[k]   <= vec_sat[k];
                        pei_pkg::CMD_SET_VEL: r_speed[k] <= vec_sat[k];
                        default: ;
                    endcase
                end
                if (i_cmd.fin_en) begin
                    unique case (i_cmd.op)
                        pei_pkg::OP_IMPULSE: r_speed[k] <= sum_spd[k];
                        pei_pkg::OP_POS:     r_pos[k]   <= sum_pos[k];
                        pei_pkg::OP_VEL:     r_speed[k] <= sum_spd[k];
                        pei_pkg::OP_DAMP: begin
                            r_speed[k] <= prod_q[k];
                            r_force[k] <= '0;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // Payload registers: operands, products, acceleration and the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dt <= i_time_step;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.load) begin
                r_vec[k] <= vec_sat[k];
            end
            if (i_cmd.mul_en) begin
                r_prod[k] <= $signed(PROD_W'(mul_a[k])) * $signed({1'b0, mul_b[k]});
            end
            if (i_cmd.fin_en && (i_cmd.op == pei_pkg::OP_ACCEL)) begin
                r_acc[k] <= prod_q[k];
            end
            if (i_cmd.out_load) begin
                r_out_pos[k]   <= r_pos[k];
                r_out_vel[k]   <= r_speed[k];
                r_out_force[k] <= r_force[k];
            end
        end
    end

    assign o_pos   = r_out_pos;
    assign o_vel   = r_out_vel;
    assign o_force = r_out_force;

endmodule

### design/particle_euler_integrator_top.sv
// Top level of the explicit Euler particle integrator.
// Depends on pei_pkg, pei_ctrl and pei_datapath.
//
// One 3-D point mass in signed Q16.16: each accepted input beat carries a
// command and a vector, and each yields exactly one result beat with the full
// state (position, velocity, accumulated force) after it. The block works on
// one item at a time. Add force, set position, set velocity and the unused
// codes go straight from accept to the output state; apply impulse runs one
// product; a tick runs four dependent products in series on the single
// multiplier per axis (force*mass_reciprocal, velocity*dt, accel*dt,
// velocity*damping), each a multiply step followed by a round/saturate/add
// step. A result waits in an output register, and the next item is taken as
// soon as the previous result is loaded there.
// Configuration writes land at once; write only while the block is idle.
module particle_euler_integrator_top #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [pei_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pei_pkg::DATA_W-1:0]        i_cfg_wdata,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [pei_pkg::CMD_W-1:0]         i_command,
    input  logic signed [pei_pkg::DATA_W-1:0] i_vec_x,
    input  logic signed [pei_pkg::DATA_W-1:0] i_vec_y,
    input  logic signed [pei_pkg::DATA_W-1:0] i_vec_z,
    input  logic [pei_pkg::DT_W-1:0]          i_time_step,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [pei_pkg::DATA_W-1:0] o_pos_x,
    output logic signed [pei_pkg::DATA_W-1:0] o_pos_y,
    output logic signed [pei_pkg::DATA_W-1:0] o_pos_z,
    output logic signed [pei_pkg::DATA_W-1:0] o_vel_x,
    output logic signed [pei_pkg::DATA_W-1:0] o_vel_y,
    output logic signed [pei_pkg::DATA_W-1:0] o_vel_z,
    output logic signed [pei_pkg::DATA_W-1:0] o_acc_force_x,
    output logic signed [pei_pkg::DATA_W-1:0] o_acc_force_y,
    output logic signed [pei_pkg::DATA_W-1:0] o_acc_force_z
);

    pei_pkg::t_dp_cmd dp_cmd;
    pei_pkg::t_word   vec [3];
    pei_pkg::t_word   pos [3];
    pei_pkg::t_word   vel [3];
    pei_pkg::t_word   acc_force [3];

    // Gather the vector lanes: x, y, z
    assign vec[0] = i_vec_x;
    assign vec[1] = i_vec_y;
    assign vec[2] = i_vec_z;

    // Sequencer: accepts beats, steps the multiply/finish ops, loads results
    pei_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // State, configuration and the three axis lanes
    pei_datapath #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .i_command   (i_command),
        .i_vec       (vec),
        .i_time_step (i_time_step),
        .o_pos       (pos),
        .o_vel       (vel),
        .o_force     (acc_force)
    );

    // Scatter the registered result lanes to the ports
    assign o_pos_x       = pos[0];
    assign o_pos_y       = pos[1];
    assign o_pos_z       = pos[2];
    assign o_vel_x       = vel[0];
    assign o_vel_y       = vel[1];
    assign o_vel_z       = vel[2];
    assign o_acc_force_x = acc_force[0];
    assign o_acc_force_y = acc_force[1];
    assign o_acc_force_z = acc_force[2];

endmodule

### design/pei_checker.sv
// Port-level checks of the particle integrator, bound to the top level.
// Depends on pei_pkg and particle_euler_integrator_top_macros.svh.
`include "particle_euler_integrator_top_macros.svh"

module pei_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [pei_pkg::CMD_W-1:0]         i_command,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [pei_pkg::DATA_W-1:0] o_pos_x,
    input logic signed [pei_pkg::DATA_W-1:0] o_pos_y,
    input logic signed [pei_pkg::DATA_W-1:0] o_pos_z,
    input logic signed [pei_pkg::DATA_W-1:0] o_vel_x,
    input logic signed [pei_pkg::DATA_W-1:0] o_vel_y,
    input logic signed [pei_pkg::DATA_W-1:0] o_vel_z,
    input logic signed [pei_pkg::DATA_W-1:0] o_acc_force_x,
    input logic signed [pei_pkg::DATA_W-1:0] o_acc_force_y,
    input logic signed [pei_pkg::DATA_W-1:0] o_acc_force_z
);

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // One item at a time: a taken beat closes the input
    `PEI_ASSERT_NEXT(a_accept_closes_input, i_clk, i_rst_n, in_beat, o_in_stall)

    // The input reopens only when a result has been loaded
    `PEI_ASSERT_IMPL(a_reopen_has_result, i_clk, i_rst_n, $fell(o_in_stall), o_out_valid)

    // A tick runs its multiply chain before the next item
    `PEI_ASSERT_NEXT(a_tick_holds_input, i_clk, i_rst_n,
        in_beat && (i_command == pei_pkg::CMD_TICK),
        o_in_stall ##1 o_in_stall ##1 o_in_stall ##1 o_in_stall)

    // A stalled result beat holds
    `PEI_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_pos_z)
        && $stable(o_vel_x) && $stable(o_vel_y) && $stable(o_vel_z)
        && $stable(o_acc_force_x) && $stable(o_acc_force_y) && $stable(o_acc_force_z))

endmodule

bind particle_euler_integrator_top pei_checker u_pei_checker (.*);
